// ===== rtl/core/symax_rx_packet_decoder_assert.svh =====
// Assertion macros for the checker file of the packet decoder.
`ifndef SYMAX_RX_PACKET_DECODER_ASSERT_SVH
`define SYMAX_RX_PACKET_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SXRX_ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("sxrx assertion failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define SXRX_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("sxrx assertion failed: next-cycle rule");

`endif

// ===== rtl/core/sxrx_pkg.sv =====
`default_nettype none

package sxrx_pkg;

   // Sizes
   localparam int HOP_CHANNELS   = 4;
   localparam int HOP_BITS       = $clog2(HOP_CHANNELS);
   localparam int TIMER_BITS     = 16;
   localparam int CFG_BITS       = 16;
   localparam int CMP_BITS       = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
   localparam int CHAN_BITS      = 7;
   localparam int ADDR_BITS      = 40;
   localparam int STICK_BITS     = 11;
   localparam int PKT_BYTES      = 10;
   localparam int CSR_INDEX_BITS = 1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIND_TIMEOUT  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOUND_TIMEOUT = 1'd1;

   // Register reset values
   localparam logic [CFG_BITS-1:0] BIND_TIMEOUT_RESET  = 16'd1000;
   localparam logic [CFG_BITS-1:0] BOUND_TIMEOUT_RESET = 16'd10000;

   // Protocol constants
   localparam logic [7:0] CHECK_SEED    = 8'h55;
   localparam logic [7:0] BIND_MARK     = 8'hAA;
   localparam logic [4:0] LOW_SKIP_CODE = 5'h06;
   localparam logic [4:0] LOW_LIMIT     = 5'h10;
   localparam logic [4:0] MID_LIMIT     = 5'h18;
   localparam logic [4:0] HIGH_LIMIT    = 5'h1e;
   localparam logic [4:0] MID_BUMP_CODE = 5'h16;
   localparam logic [4:0] TOP_EVEN_CODE = 5'h1e;

   // Stick scaling: value * STICK_SPAN / STICK_DIV + STICK_BASE
   localparam int STICK_SPAN   = 1000;
   localparam int STICK_DIV    = 255;
   localparam int STICK_BASE   = 1000;
   localparam int PITCH_MIRROR = 3000;

   // Hop tables
   localparam logic [7:0] BIND_HOPS [HOP_CHANNELS] = '{8'h4b, 8'h30, 8'h40, 8'h20};
   localparam logic [7:0] FH_LOW    [HOP_CHANNELS] = '{8'h0a, 8'h1a, 8'h2a, 8'h3a};
   localparam logic [7:0] FH_MID    [HOP_CHANNELS] = '{8'h2a, 8'h0a, 8'h42, 8'h22};
   localparam logic [7:0] FH_HIGH   [HOP_CHANNELS] = '{8'h1a, 8'h3a, 8'h12, 8'h32};
   localparam logic [7:0] FH_TOP_EVEN [HOP_CHANNELS] = '{8'h21, 8'h41, 8'h18, 8'h38};
   localparam logic [7:0] FH_TOP_ODD  [HOP_CHANNELS] = '{8'h21, 8'h41, 8'h19, 8'h39};

   // Payload: byte k sits at bits 8k+7:8k
   typedef logic [PKT_BYTES-1:0][7:0] pkt_type;

   typedef struct packed {
      logic                      we;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CFG_BITS-1:0]       data;
   } csr_write_type;

   typedef struct packed {
      logic                 decoded_valid;
      logic                 checksum_error;
      logic                 is_bound;
      logic                 channel_changed;
      logic [CHAN_BITS-1:0] tune_channel;
      logic                 address_load;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/sxrx_stick.sv =====
`default_nettype none

module sxrx_stick (
   input  wire logic [7:0]                      stick_byte,
   input  wire logic                            sign_mag,
   output logic [sxrx_pkg::STICK_BITS-1:0]      stick_value
);
   import sxrx_pkg::*;

   logic [7:0]  mag;
   logic [17:0] prod;
   logic [25:0] recip;
   logic [9:0]  quot_est;
   logic [17:0] back;
   logic [17:0] rem;
   logic [9:0]  quot;

   // Fold the sign-magnitude byte: low half counts down from 0x7f
   assign mag = (sign_mag && !stick_byte[7]) ? {1'b0, ~stick_byte[6:0]} : stick_byte;

   // Scale up, then divide by 255 via multiply by 257 / 65536
   assign prod     = {10'd0, mag} * 18'(STICK_SPAN);
   assign recip    = {prod, 8'd0} + {8'd0, prod};
   assign quot_est = recip[25:16];

   // Estimate is exact or one short; correct with one compare
   assign back = {quot_est, 8'd0} - {8'd0, quot_est};
   assign rem  = prod - back;
   assign quot = (rem >= 18'(STICK_DIV)) ? quot_est + 10'd1 : quot_est;

   assign stick_value = {1'b0, quot} + 11'(STICK_BASE);

endmodule

`default_nettype wire

// ===== rtl/core/sxrx_state.sv =====
`default_nettype none

module sxrx_state (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sxrx_pkg::csr_write_type             csr,
   input  wire logic                                fire,
   input  wire logic                                func,
   input  wire sxrx_pkg::pkt_type                   pkt,
   output sxrx_pkg::status_type                     status,
   output logic [sxrx_pkg::ADDR_BITS-1:0]           rx_address
);
   import sxrx_pkg::*;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   logic [CFG_BITS-1:0]   bind_timeout_ff,  bind_timeout_in;
   logic [CFG_BITS-1:0]   bound_timeout_ff, bound_timeout_in;
   logic                  bound_ff,  bound_in;
   logic                  seen_ff,   seen_in;
   logic [CHAN_BITS-1:0]  hop_table_ff [HOP_CHANNELS];
   logic [CHAN_BITS-1:0]  hop_table_in [HOP_CHANNELS];
   logic [HOP_BITS-1:0]   hop_index_ff, hop_index_in;
   logic [TIMER_BITS-1:0] elapsed_ff,   elapsed_in;
   logic [ADDR_BITS-1:0]  address_ff,   address_in;

   logic [CHAN_BITS-1:0]  new_table [HOP_CHANNELS];
   logic [4:0]            code;
   logic [4:0]            low_off;
   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [CFG_BITS-1:0]   limit;
   logic [7:0]            check;
   logic                  bind_hit;
   logic [HOP_BITS-1:0]   next_index;

   // Derive the bound hop table from address byte zero
   always_comb begin
      code    = pkt[4][4:0];
      low_off = (code == LOW_SKIP_CODE) ? LOW_SKIP_CODE + 5'd1 : code;
      for (int i = 0; i < HOP_CHANNELS; i++) begin
         if (code < LOW_LIMIT) begin
            new_table[i] = CHAN_BITS'(FH_LOW[i] + {3'd0, low_off});
         end else if (code < MID_LIMIT) begin
            new_table[i] = CHAN_BITS'(FH_MID[i] + {5'd0, code[2:0]} +
                           {7'd0, (code == MID_BUMP_CODE) && (i < 2)});
         end else if (code < HIGH_LIMIT) begin
            new_table[i] = CHAN_BITS'(FH_HIGH[i] + {5'd0, code[2:0]});
         end else if (code == TOP_EVEN_CODE) begin
            new_table[i] = CHAN_BITS'(FH_TOP_EVEN[i]);
         end else begin
            new_table[i] = CHAN_BITS'(FH_TOP_ODD[i]);
         end
      end
   end

   // Timer, checksum and bind detection
   always_comb begin
      elapsed_inc = (elapsed_ff != TIMER_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
      limit       = seen_ff ? bound_timeout_ff : bind_timeout_ff;
      check       = pkt[0] ^ pkt[1] ^ pkt[2] ^ pkt[3] ^ pkt[4] ^
                    pkt[5] ^ pkt[6] ^ pkt[7] ^ pkt[8];
      check       = check + CHECK_SEED;
      bind_hit    = (pkt[5] == BIND_MARK) && (pkt[6] == BIND_MARK) &&
                    (pkt[7] == BIND_MARK);
      next_index  = hop_index_ff + 1'b1;
   end

   // Next state and result flags for the item in the input register
   always_comb begin
      bind_timeout_in  = bind_timeout_ff;
      bound_timeout_in = bound_timeout_ff;
      bound_in         = bound_ff;
      seen_in          = seen_ff;
      hop_table_in     = hop_table_ff;
      hop_index_in     = hop_index_ff;
      elapsed_in       = elapsed_ff;
      address_in       = address_ff;
      status           = '0;

      if (csr.we) begin
         case (csr.index)
            CSR_BIND_TIMEOUT:  bind_timeout_in  = csr.data;
            CSR_BOUND_TIMEOUT: bound_timeout_in = csr.data;
            default: ;
         endcase
      end

      if (func) begin
         // Tick: advance timer, hop once past the timeout
         elapsed_in = elapsed_inc;
         if (CMP_BITS'(elapsed_inc) > CMP_BITS'(limit)) begin
            status.channel_changed = 1'b1;
            status.tune_channel    = hop_table_ff[hop_index_ff];
            hop_index_in           = next_index;
            elapsed_in             = '0;
         end
      end else begin
         // Payload: restart timer and hop, then bind or check the checksum
         elapsed_in             = '0;
         status.channel_changed = 1'b1;
         status.tune_channel    = hop_table_ff[hop_index_ff];
         hop_index_in           = next_index;
         if (!bound_ff) begin
            if (bind_hit) begin
               address_in          = {pkt[0], pkt[1], pkt[2], pkt[3], pkt[4]};
               status.address_load = 1'b1;
               hop_table_in        = new_table;
               bound_in            = 1'b1;
               status.tune_channel = new_table[next_index];
               hop_index_in        = next_index + 1'b1;
            end
         end else if (check != pkt[9]) begin
            status.checksum_error = 1'b1;
         end else begin
            seen_in              = 1'b1;
            status.decoded_valid = 1'b1;
         end
      end

      status.is_bound = bound_in;
      rx_address      = address_in;
   end

   // Timeouts take writes every cycle; other state advances only when the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         bind_timeout_ff  <= BIND_TIMEOUT_RESET;
         bound_timeout_ff <= BOUND_TIMEOUT_RESET;
         bound_ff         <= 1'b0;
         seen_ff          <= 1'b0;
         for (int i = 0; i < HOP_CHANNELS; i++) begin
            hop_table_ff[i] <= CHAN_BITS'(BIND_HOPS[i]);
         end
         hop_index_ff     <= HOP_BITS'(1);
         elapsed_ff       <= '0;
         address_ff       <= '0;
      end else begin
         bind_timeout_ff  <= bind_timeout_in;
         bound_timeout_ff <= bound_timeout_in;
         if (fire) begin
            bound_ff     <= bound_in;
            seen_ff      <= seen_in;
            hop_table_ff <= hop_table_in;
            hop_index_ff <= hop_index_in;
            elapsed_ff   <= elapsed_in;
            address_ff   <= address_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/symax_rx_packet_decoder.sv =====
// Receiver packet decoder for a four-channel hopping radio link. Each item on
// req_ is a 10-byte payload or a one-microsecond tick; every item gives exactly
// one result item on rsp_. The block takes one item per clock cycle while
// rsp_tready is high: an item is held in the input register, where timer,
// hop, bind and checksum logic plus the four stick scalers (multiply by 1000,
// divide by 255 through a reciprocal and one correction) update the state, and
// the result is then held in the output register. While rsp_tready is low the
// output register holds and the input register fills, after which req_tready
// drops. The user must write timeouts through the csr_ port only while no item
// is in flight; the block does not enforce this.
`default_nettype none

module symax_rx_packet_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration writes
   input  wire logic        csr_we,
   input  wire logic [sxrx_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sxrx_pkg::CFG_BITS-1:0]       csr_wdata,
   // Input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // pkt_byte0 .. pkt_byte9, 8 bits each
   input  wire logic        req_tuser,   // func
   // Result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // is_bound, channel_changed, tune_channel,
                                         // address_load, rx_address, throttle,
                                         // pitch, yaw, roll, 2 bits zero pad
   output logic [1:0]       rsp_tuser    // decoded_valid, checksum_error
);
   import sxrx_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_func_ff;
   pkt_type               s1_pkt_ff;
   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff;
   logic [ADDR_BITS-1:0]  out_address_ff;
   logic [STICK_BITS-1:0] out_throttle_ff, out_pitch_ff, out_yaw_ff, out_roll_ff;

   logic                  advance;
   logic                  accept;
   csr_write_type         csr;
   status_type            status;
   logic [ADDR_BITS-1:0]  address;
   logic [STICK_BITS-1:0] thr_raw, pit_raw, yaw_raw, rol_raw;
   logic [STICK_BITS-1:0] pit_rev;

   // Handshake: move on when the output register is free or being emptied
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || advance;
   assign accept       = req_tvalid && req_tready;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   sxrx_state u_state (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .fire       (advance),
      .func       (s1_func_ff),
      .pkt        (s1_pkt_ff),
      .status     (status),
      .rx_address (address)
   );

   sxrx_stick u_throttle (.stick_byte(s1_pkt_ff[0]), .sign_mag(1'b0), .stick_value(thr_raw));
   sxrx_stick u_pitch    (.stick_byte(s1_pkt_ff[1]), .sign_mag(1'b1), .stick_value(pit_raw));
   sxrx_stick u_yaw      (.stick_byte(s1_pkt_ff[2]), .sign_mag(1'b1), .stick_value(yaw_raw));
   sxrx_stick u_roll     (.stick_byte(s1_pkt_ff[3]), .sign_mag(1'b1), .stick_value(rol_raw));

   // Reverse pitch about the mid-stick point
   assign pit_rev = STICK_BITS'(12'(PITCH_MIRROR) - {1'b0, pit_raw});

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register: load on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= req_tuser;
         s1_pkt_ff  <= req_tdata;
      end
   end

   // Result register: load when the item moves on, zero sticks unless decoded
   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff   <= status;
         out_address_ff  <= address;
         out_throttle_ff <= status.decoded_valid ? thr_raw : '0;
         out_pitch_ff    <= status.decoded_valid ? pit_rev : '0;
         out_yaw_ff      <= status.decoded_valid ? yaw_raw : '0;
         out_roll_ff     <= status.decoded_valid ? rol_raw : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_status_ff.checksum_error, out_status_ff.decoded_valid};
   assign rsp_tdata  = {2'b00, out_roll_ff, out_yaw_ff, out_pitch_ff, out_throttle_ff,
                        out_address_ff, out_status_ff.address_load,
                        out_status_ff.tune_channel, out_status_ff.channel_changed,
                        out_status_ff.is_bound};

endmodule

`default_nettype wire

// ===== rtl/core/sxrx_checker.sv =====
`default_nettype none

`include "symax_rx_packet_decoder_assert.svh"

module sxrx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // No result is shown straight after reset
   `SXRX_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // A stalled result holds its payload
   `SXRX_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Decoded sticks only come from a bound payload with a good checksum, which always hops
   `SXRX_ASSERT_SAME(a_decode_bound, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[0] && rsp_tdata[1] && !rsp_tuser[1])

   // Decoded throttle stays in the stick range
   `SXRX_ASSERT_SAME(a_throttle_range, clock, reset, rsp_tvalid && rsp_tuser[0], (rsp_tdata[60:50] >= 11'd1000) && (rsp_tdata[60:50] <= 11'd2000))

endmodule

bind symax_rx_packet_decoder sxrx_checker u_sxrx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
